// File: rtl/rnpp_pkg.sv
// shared types, codes and helpers for the ray nearest point picker
// no dependencies
package rnpp_pkg;

  localparam int SET_SLOTS     = 16;
  localparam int WORDS_PER_SET = 12;
  localparam logic [3:0] WORD_VISIBLE = 4'd12;
  localparam logic [63:0] SAT62 = 64'h3FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_BEGIN = 2'd1;
  localparam logic [1:0] FUNC_POINT = 2'd2;
  localparam logic [1:0] FUNC_END   = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         set_index;
    logic [18:0]        point_index;
    logic [3:0]         word_index;
    logic signed [31:0] word_value;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
  } in_beat_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  found_set;
    logic [18:0] found_point;
    logic [61:0] found_dist_sq;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OUT,
    ST_NORM,
    ST_SSQ,
    ST_DIV,
    ST_RUPD,
    ST_UST,
    ST_MRD,
    ST_MMUL,
    ST_DOT,
    ST_CMUL,
    ST_CSQ,
    ST_CMP
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -52'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// File: rtl/rnpp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module rnpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 192
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/ray_nearest_point_pick.sv
// nearest stored point to a pick line, sequential datapath around the matrix ram
// depends on rnpp_pkg and rnpp_ram
//
// usage: the host loads, per point set, twelve 3x4 transform words and a
// visible bit (func load), then sends a begin beat with two line points,
// a run of point beats and an end beat. the end beat yields one out beat
// with the nearest accepted point and its squared line distance.
// cfg_we writes pick_radius; it is used at the next begin or end.
// a point beat is paced by the one matrix ram read port (each of the
// twelve words is read, then multiplied) and the two shared multipliers.
// a begin beat normalizes, sums the squares and then runs
// (ROOT_ITERS + 3) radix-2 divisions.
// in_stall is high whenever a beat is at work; one beat at a time.
// a finished out beat waits in its register while out_stall is high;
// load, begin and point beats are still taken then, a further end beat
// waits for the register. reset clears visible bits, line and best;
// matrix words are undefined until loaded.
module ray_nearest_point_pick import rnpp_pkg::*; #(
  parameter int NUM_SETS   = 16,
  parameter int MAX_POINTS = 524288,
  parameter int FRAC_BITS  = 16,
  parameter int ROOT_ITERS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data,
  input  logic      cfg_we,
  input  logic [30:0] cfg_wdata
);

  localparam int SETS_USED = (NUM_SETS < SET_SLOTS) ? NUM_SETS : SET_SLOTS;
  localparam int MAT_DEPTH = SETS_USED * WORDS_PER_SET;
  localparam int MAT_AW    = $clog2(MAT_DEPTH);
  localparam int IT_W      = $clog2(ROOT_ITERS + 1);

  state_t state_r, state_nxt;

  logic [61:0] radius_sq_r;
  logic [15:0] vis_r, vis_nxt;
  logic signed [31:0] origin_r [3];
  logic signed [31:0] origin_nxt [3];
  logic signed [31:0] unit_r [3];
  logic signed [31:0] unit_nxt [3];
  logic line_valid_r, line_valid_nxt;
  logic [63:0] best_dist_r, best_dist_nxt;
  logic [3:0]  best_set_r, best_set_nxt;
  logic [18:0] best_point_r, best_point_nxt;
  logic best_found_r, best_found_nxt;
  logic out_valid_r, out_valid_nxt;
  out_beat_t out_data_r, out_data_nxt;

  logic [3:0]  pt_set_r, pt_set_nxt;
  logic [18:0] pt_idx_r, pt_idx_nxt;
  logic signed [31:0] p_r [3];
  logic signed [31:0] p_nxt [3];
  logic signed [31:0] n_r [3];
  logic signed [31:0] n_nxt [3];
  logic [1:0] row_r, row_nxt, col_r, col_nxt, idx_r, idx_nxt;
  logic signed [51:0] acc_p_r, acc_p_nxt, acc_n_r, acc_n_nxt;
  logic signed [31:0] tp_r [3];
  logic signed [31:0] tp_nxt [3];
  logic signed [31:0] tn_r [3];
  logic signed [31:0] tn_nxt [3];
  logic signed [67:0] dot_r, dot_nxt;
  logic signed [65:0] c_r, c_nxt;
  logic [63:0] dsq_r, dsq_nxt;
  logic sat_r, sat_nxt;

  logic [32:0] m_r [3];
  logic [32:0] m_nxt [3];
  logic [2:0]  neg_r, neg_nxt;
  logic [63:0] s_r, s_nxt;
  logic [33:0] r_r, r_nxt;
  logic [IT_W-1:0] it_r, it_nxt;
  logic [63:0] num_r, num_nxt, quo_r, quo_nxt;
  logic [34:0] rem_r, rem_nxt;
  logic [6:0]  dcnt_r, dcnt_nxt;
  logic div_root_r, div_root_nxt;

  logic signed [33:0] ma_x, ma_y, mb_x, mb_y;
  logic signed [67:0] ma_p, mb_p;

  logic accept, set_ok, pidx_ok, out_free;
  logic [32:0] top;
  logic signed [32:0] q [3];
  logic signed [32:0] d_in [3];
  logic [1:0] ia, ib;

  logic ram_we, ram_re;
  logic [MAT_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_rdata;
  logic signed [31:0] word;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign set_ok    = 32'(in_data.set_index) < 32'(SETS_USED);
  assign pidx_ok   = 32'(in_data.point_index) < 32'(MAX_POINTS);
  assign word      = ram_rdata;

  assign ma_p = ma_x * ma_y;
  assign mb_p = mb_x * mb_y;

  assign d_in[0] = 33'(in_data.ax) - 33'(in_data.bx);
  assign d_in[1] = 33'(in_data.ay) - 33'(in_data.by);
  assign d_in[2] = 33'(in_data.az) - 33'(in_data.bz);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = 33'(tp_r[i]) - 33'(origin_r[i]);
    end
    top = m_r[0];
    if (m_r[1] > top) begin
      top = m_r[1];
    end
    if (m_r[2] > top) begin
      top = m_r[2];
    end
    case (idx_r)
      2'd0:    begin ia = 2'd1; ib = 2'd2; end
      2'd1:    begin ia = 2'd2; ib = 2'd0; end
      default: begin ia = 2'd0; ib = 2'd1; end
    endcase
  end

  // matrix ram
  assign ram_we = accept && in_data.func == FUNC_LOAD && set_ok
                  && in_data.word_index < WORD_VISIBLE;
  assign ram_waddr = MAT_AW'(8'({in_data.set_index, 3'b000}) + 8'({in_data.set_index, 2'b00})
                     + 8'(in_data.word_index));
  assign ram_re = (state_r == ST_MRD);
  assign ram_raddr = MAT_AW'(8'({pt_set_r, 3'b000}) + 8'({pt_set_r, 2'b00})
                     + 8'({row_r, col_r}));

  rnpp_ram #(
    .WIDTH(32),
    .DEPTH(MAT_DEPTH)
  ) u_mat_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_data.word_value),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data.func)
            FUNC_BEGIN: begin
              if (d_in[0] != '0 || d_in[1] != '0 || d_in[2] != '0) begin
                state_nxt = ST_NORM;
              end
            end
            FUNC_POINT: begin
              if (set_ok && pidx_ok && line_valid_r && vis_r[in_data.set_index]) begin
                state_nxt = ST_MRD;
              end
            end
            FUNC_END:  state_nxt = ST_OUT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      ST_NORM: begin
        if (top < 33'h4000_0000 && top >= 33'h2000_0000) begin
          state_nxt = ST_SSQ;
        end
      end
      ST_SSQ:  if (idx_r == 2'd2) state_nxt = ST_DIV;
      ST_DIV: begin
        if (dcnt_r == 7'd63) begin
          state_nxt = div_root_r ? ST_RUPD : ST_UST;
        end
      end
      ST_RUPD: state_nxt = ST_DIV;
      ST_UST:  state_nxt = (idx_r == 2'd2) ? ST_IDLE : ST_DIV;
      ST_MRD:  state_nxt = ST_MMUL;
      ST_MMUL: state_nxt = (col_r == 2'd3 && row_r == 2'd2) ? ST_DOT : ST_MRD;
      ST_DOT: begin
        if (idx_r == 2'd2) begin
          state_nxt = dot_nxt[67] ? ST_IDLE : ST_CMUL;
        end
      end
      ST_CMUL: state_nxt = ST_CSQ;
      ST_CSQ:  state_nxt = (idx_r == 2'd2) ? ST_CMP : ST_CMUL;
      ST_CMP:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    logic [34:0] rem_sh;
    logic        ge;
    logic [34:0] rsum;
    logic [33:0] rn;
    logic signed [31:0] qv;
    logic signed [68:0] diff;
    logic [65:0] mag;
    logic [63:0] dfin;

    vis_nxt        = vis_r;
    origin_nxt     = origin_r;
    unit_nxt       = unit_r;
    line_valid_nxt = line_valid_r;
    best_dist_nxt  = best_dist_r;
    best_set_nxt   = best_set_r;
    best_point_nxt = best_point_r;
    best_found_nxt = best_found_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    pt_set_nxt     = pt_set_r;
    pt_idx_nxt     = pt_idx_r;
    p_nxt          = p_r;
    n_nxt          = n_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    idx_nxt        = idx_r;
    acc_p_nxt      = acc_p_r;
    acc_n_nxt      = acc_n_r;
    tp_nxt         = tp_r;
    tn_nxt         = tn_r;
    dot_nxt        = dot_r;
    c_nxt          = c_r;
    dsq_nxt        = dsq_r;
    sat_nxt        = sat_r;
    m_nxt          = m_r;
    neg_nxt        = neg_r;
    s_nxt          = s_r;
    r_nxt          = r_r;
    it_nxt         = it_r;
    num_nxt        = num_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    dcnt_nxt       = dcnt_r;
    div_root_nxt   = div_root_r;
    ma_x = '0;
    ma_y = '0;
    mb_x = '0;
    mb_y = '0;
    rem_sh = {rem_r[33:0], num_r[63]};
    ge     = rem_sh >= {1'b0, r_r};
    rsum   = {1'b0, r_r} + quo_r[34:0];
    rn     = (rsum[34:1] == '0) ? 34'd1 : rsum[34:1];
    qv     = quo_r[31:0];
    diff   = '0;
    mag    = c_r[65] ? 66'(-c_r) : 66'(c_r);
    dfin   = (sat_r || dsq_r > SAT62) ? SAT62 : dsq_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.func)
            FUNC_LOAD: begin
              if (set_ok && in_data.word_index == WORD_VISIBLE) begin
                vis_nxt[in_data.set_index] = in_data.word_value[0];
              end
            end
            FUNC_BEGIN: begin
              origin_nxt[0]  = in_data.ax;
              origin_nxt[1]  = in_data.ay;
              origin_nxt[2]  = in_data.az;
              for (int i = 0; i < 3; i++) begin
                unit_nxt[i] = '0;
                neg_nxt[i]  = d_in[i][32];
                m_nxt[i]    = d_in[i][32] ? 33'(-d_in[i]) : 33'(d_in[i]);
              end
              line_valid_nxt = 1'b0;
              best_dist_nxt  = 64'(radius_sq_r);
              best_set_nxt   = '0;
              best_point_nxt = '0;
              best_found_nxt = 1'b0;
            end
            FUNC_POINT: begin
              pt_set_nxt = in_data.set_index;
              pt_idx_nxt = in_data.point_index;
              p_nxt[0] = in_data.ax;
              p_nxt[1] = in_data.ay;
              p_nxt[2] = in_data.az;
              n_nxt[0] = in_data.bx;
              n_nxt[1] = in_data.by;
              n_nxt[2] = in_data.bz;
              row_nxt   = '0;
              col_nxt   = '0;
              acc_p_nxt = '0;
              acc_n_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.found         = best_found_r;
          out_data_nxt.found_set     = best_found_r ? best_set_r : '0;
          out_data_nxt.found_point   = best_found_r ? best_point_r : '0;
          out_data_nxt.found_dist_sq = best_found_r ? best_dist_r[61:0] : '0;
          best_dist_nxt  = 64'(radius_sq_r);
          best_set_nxt   = '0;
          best_point_nxt = '0;
          best_found_nxt = 1'b0;
        end
      end
      ST_NORM: begin
        if (top >= 33'h4000_0000) begin
          for (int i = 0; i < 3; i++) m_nxt[i] = m_r[i] >> 1;
        end else if (top < 33'h2000_0000) begin
          for (int i = 0; i < 3; i++) m_nxt[i] = m_r[i] << 1;
        end else begin
          idx_nxt = '0;
          s_nxt   = '0;
        end
      end
      ST_SSQ: begin
        ma_x  = 34'(m_r[idx_r]);
        ma_y  = 34'(m_r[idx_r]);
        s_nxt = s_r + ma_p[63:0];
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd2) begin
          r_nxt        = 34'h4000_0000;
          it_nxt       = '0;
          num_nxt      = s_nxt;
          rem_nxt      = '0;
          quo_nxt      = '0;
          dcnt_nxt     = '0;
          div_root_nxt = 1'b1;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? rem_sh - {1'b0, r_r} : rem_sh;
        num_nxt  = {num_r[62:0], 1'b0};
        quo_nxt  = {quo_r[62:0], ge};
        dcnt_nxt = dcnt_r + 7'd1;
      end
      ST_RUPD: begin
        r_nxt    = rn;
        it_nxt   = it_r + 1'b1;
        rem_nxt  = '0;
        quo_nxt  = '0;
        dcnt_nxt = '0;
        if (32'(it_r) + 1 == ROOT_ITERS) begin
          idx_nxt      = '0;
          num_nxt      = 64'(m_r[0]) << FRAC_BITS;
          div_root_nxt = 1'b0;
        end else begin
          num_nxt = s_r;
        end
      end
      ST_UST: begin
        unit_nxt[idx_r] = neg_r[idx_r] ? -qv : qv;
        rem_nxt  = '0;
        quo_nxt  = '0;
        dcnt_nxt = '0;
        if (idx_r == 2'd2) begin
          line_valid_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 2'd1;
          num_nxt = 64'(m_r[idx_r + 2'd1]) << FRAC_BITS;
        end
      end
      ST_MMUL: begin
        if (col_r != 2'd3) begin
          ma_x = 34'(word);
          ma_y = 34'(p_r[col_r]);
          mb_x = 34'(word);
          mb_y = 34'(n_r[col_r]);
          acc_p_nxt = acc_p_r + 52'(ma_p >>> FRAC_BITS);
          acc_n_nxt = acc_n_r + 52'(mb_p >>> FRAC_BITS);
          col_nxt   = col_r + 2'd1;
        end else begin
          tp_nxt[row_r] = sat32(acc_p_r + 52'(word));
          tn_nxt[row_r] = sat32(acc_n_r);
          acc_p_nxt = '0;
          acc_n_nxt = '0;
          col_nxt   = '0;
          row_nxt   = row_r + 2'd1;
          idx_nxt   = '0;
          dot_nxt   = '0;
        end
      end
      ST_DOT: begin
        ma_x    = 34'(unit_r[idx_r]);
        ma_y    = 34'(tn_r[idx_r]);
        dot_nxt = dot_r + ma_p;
        idx_nxt = idx_r + 2'd1;
        if (idx_r == 2'd2) begin
          idx_nxt = '0;
          dsq_nxt = '0;
          sat_nxt = 1'b0;
        end
      end
      ST_CMUL: begin
        ma_x  = 34'(unit_r[ia]);
        ma_y  = 34'(q[ib]);
        mb_x  = 34'(unit_r[ib]);
        mb_y  = 34'(q[ia]);
        diff  = 69'(ma_p) - 69'(mb_p);
        c_nxt = 66'(diff >>> FRAC_BITS);
      end
      ST_CSQ: begin
        if (mag[65:31] != '0) begin
          sat_nxt = 1'b1;
        end else begin
          ma_x    = 34'(mag[30:0]);
          ma_y    = 34'(mag[30:0]);
          dsq_nxt = dsq_r + 64'(ma_p[61:0]);
        end
        idx_nxt = idx_r + 2'd1;
      end
      ST_CMP: begin
        if (dfin < best_dist_r) begin
          best_dist_nxt  = dfin;
          best_set_nxt   = pt_set_r;
          best_point_nxt = pt_idx_r;
          best_found_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      radius_sq_r   <= 62'h1_0000_0000;
      vis_r         <= '0;
      line_valid_r  <= 1'b0;
      best_dist_r   <= 64'h1_0000_0000;
      best_set_r    <= '0;
      best_point_r  <= '0;
      best_found_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        origin_r[i] <= '0;
        unit_r[i]   <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      if (cfg_we) begin
        radius_sq_r <= 62'(cfg_wdata) * 62'(cfg_wdata);
      end
      vis_r         <= vis_nxt;
      line_valid_r  <= line_valid_nxt;
      best_dist_r   <= best_dist_nxt;
      best_set_r    <= best_set_nxt;
      best_point_r  <= best_point_nxt;
      best_found_r  <= best_found_nxt;
      out_valid_r   <= out_valid_nxt;
      origin_r      <= origin_nxt;
      unit_r        <= unit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    pt_set_r   <= pt_set_nxt;
    pt_idx_r   <= pt_idx_nxt;
    p_r        <= p_nxt;
    n_r        <= n_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    idx_r      <= idx_nxt;
    acc_p_r    <= acc_p_nxt;
    acc_n_r    <= acc_n_nxt;
    tp_r       <= tp_nxt;
    tn_r       <= tn_nxt;
    dot_r      <= dot_nxt;
    c_r        <= c_nxt;
    dsq_r      <= dsq_nxt;
    sat_r      <= sat_nxt;
    m_r        <= m_nxt;
    neg_r      <= neg_nxt;
    s_r        <= s_nxt;
    r_r        <= r_nxt;
    it_r       <= it_nxt;
    num_r      <= num_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dcnt_r     <= dcnt_nxt;
    div_root_r <= div_root_nxt;
  end

`ifndef SYNTHESIS
  a_end_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.func == FUNC_END) |=> (state_r == ST_OUT))
    else $error("end beat did not reach the output stage");

  a_line_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
    line_valid_r |-> (unit_r[0] != '0 || unit_r[1] != '0 || unit_r[2] != '0))
    else $error("valid line with zero direction");

  a_best_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !best_found_r |-> (best_set_r == '0 && best_point_r == '0))
    else $error("best index left without a found point");
`endif

endmodule
